// ===== src/iss_pkg.sv =====
// Types, codes and constants shared by the start/stop sequencer modules.
`timescale 1ns / 1ps
package iss_pkg;

  // Mode codes
  localparam logic [3:0] MODE_OFF       = 4'd0;
  localparam logic [3:0] MODE_ONDELAY   = 4'd1;
  localparam logic [3:0] MODE_AWAIT     = 4'd2;
  localparam logic [3:0] MODE_RUN       = 4'd3;
  localparam logic [3:0] MODE_SHUT      = 4'd4;
  localparam logic [3:0] MODE_FAULTED   = 4'd5;
  localparam logic [3:0] MODE_FAULTDOWN = 4'd6;
  localparam logic [3:0] MODE_FAULTOFF  = 4'd7;
  localparam logic [3:0] MODE_DIAG      = 4'd8;

  // Fault codes
  localparam logic [1:0] FAULT_NONE   = 2'd0;
  localparam logic [1:0] FAULT_BUS_OV = 2'd1;
  localparam logic [1:0] FAULT_TOGGLE = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_ON_DELAY    = 3'd0;
  localparam logic [2:0] REG_OFF_DELAY   = 3'd1;
  localparam logic [2:0] REG_FAULT_PERST = 3'd2;
  localparam logic [2:0] REG_MIN_VIN     = 3'd3;
  localparam logic [2:0] REG_BUS_SOFT    = 3'd4;
  localparam logic [2:0] REG_BUS_HARD    = 3'd5;
  localparam logic [2:0] REG_FAULT_OVR   = 3'd6;
  localparam logic [2:0] REG_DIAG_DIS    = 3'd7;

  // Register reset values
  localparam logic [23:0] RST_ON_DELAY    = 24'd5000000;
  localparam logic [23:0] RST_OFF_DELAY   = 24'd100000;
  localparam logic [23:0] RST_FAULT_PERST = 24'd2000000;
  localparam logic [15:0] RST_MIN_VIN     = 16'd4800;
  localparam logic [15:0] RST_BUS_SOFT    = 16'd6400;
  localparam logic [15:0] RST_BUS_HARD    = 16'd7200;

  // Fixed timing and levels
  localparam logic [22:0] ALARM_PERIOD = 23'd5000000;
  localparam logic [22:0] CANCEL_IDLE  = 23'd5000000;
  localparam logic [2:0]  DIAG_CANCELS = 3'd5;
  localparam logic [2:0]  CANCEL_MAX   = 3'd7;
  localparam logic [7:0]  LVL_OFF      = 8'd0;
  localparam logic [7:0]  LVL_HALF     = 8'd127;
  localparam logic [7:0]  LVL_FULL     = 8'd255;

  typedef struct packed {
    logic [23:0] on_delay_ticks;
    logic [23:0] off_delay_ticks;
    logic [23:0] fault_persist_ticks;
    logic [15:0] min_input_voltage;
    logic [15:0] bus_soft_limit;
    logic [15:0] bus_hard_limit;
    logic        fault_override;
    logic        diag_entry_disable;
  } iss_cfg_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [23:0] delay_counter;
    logic [23:0] fault_timer;
    logic        fault_running;
    logic [22:0] alarm_timer;
    logic [2:0]  cancel_count;
    logic [22:0] cancel_idle_timer;
    logic        cancel_idle_active;
    logic [1:0]  latched_fault;
  } iss_state_t;

  typedef struct packed {
    logic        switch_on;
    logic        button_pressed;
    logic [15:0] input_voltage;
    logic [15:0] bus_voltage;
    logic        zero_crossing;
  } iss_in_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [7:0]  green_level;
    logic [7:0]  red_level;
    logic        power_stage_enable;
    logic [23:0] ramp_remaining;
    logic        alarm_pulse;
    logic [1:0]  fault_code;
  } iss_out_t;

endpackage

// ===== src/iss_cfg.sv =====
// Configuration register file of the start/stop sequencer.
`timescale 1ns / 1ps
module iss_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [23:0]        wr_data,
  output iss_pkg::iss_cfg_t  cfg
);
  import iss_pkg::*;

  iss_cfg_t cfg_r, cfg_nxt;

  // Write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_ON_DELAY:    cfg_nxt.on_delay_ticks      = wr_data;
        REG_OFF_DELAY:   cfg_nxt.off_delay_ticks     = wr_data;
        REG_FAULT_PERST: cfg_nxt.fault_persist_ticks = wr_data;
        REG_MIN_VIN:     cfg_nxt.min_input_voltage   = wr_data[15:0];
        REG_BUS_SOFT:    cfg_nxt.bus_soft_limit      = wr_data[15:0];
        REG_BUS_HARD:    cfg_nxt.bus_hard_limit      = wr_data[15:0];
        REG_FAULT_OVR:   cfg_nxt.fault_override      = wr_data[0];
        REG_DIAG_DIS:    cfg_nxt.diag_entry_disable  = wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_delay_ticks      <= RST_ON_DELAY;
      cfg_r.off_delay_ticks     <= RST_OFF_DELAY;
      cfg_r.fault_persist_ticks <= RST_FAULT_PERST;
      cfg_r.min_input_voltage   <= RST_MIN_VIN;
      cfg_r.bus_soft_limit      <= RST_BUS_SOFT;
      cfg_r.bus_hard_limit      <= RST_BUS_HARD;
      cfg_r.fault_override      <= 1'b0;
      cfg_r.diag_entry_disable  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/iss_step.sv =====
// One-tick step of the sequencer: next state and result word from state and tick.
`timescale 1ns / 1ps
module iss_step (
  input  iss_pkg::iss_cfg_t   cfg,
  input  iss_pkg::iss_state_t st_cur,
  input  iss_pkg::iss_in_t    tick,
  output iss_pkg::iss_state_t st_next,
  output iss_pkg::iss_out_t   res
);
  import iss_pkg::*;

  iss_state_t st;
  logic       alarm;
  logic       hard;
  logic [7:0] green;
  logic [7:0] red;

  always_comb begin
    st    = st_cur;
    alarm = 1'b0;
    red   = LVL_OFF;
    green = LVL_OFF;
    hard  = tick.bus_voltage > cfg.bus_hard_limit;

    // Zero crossing releases the wait before the mode's own step
    if (st.mode == MODE_AWAIT && tick.zero_crossing) begin
      st.mode = MODE_RUN;
    end

    // Mode step
    unique case (st.mode)
      MODE_OFF: begin
        if (tick.switch_on) begin
          st.delay_counter = cfg.on_delay_ticks;
          st.mode          = MODE_ONDELAY;
        end
      end
      MODE_ONDELAY: begin
        if (!tick.switch_on) begin
          st.mode = MODE_OFF;
          if (st.cancel_count < CANCEL_MAX) begin
            st.cancel_count = st.cancel_count + 3'd1;
          end
          st.cancel_idle_timer  = CANCEL_IDLE;
          st.cancel_idle_active = 1'b1;
        end else begin
          if (st.delay_counter != 24'd0) begin
            st.delay_counter = st.delay_counter - 24'd1;
          end
          if (st.delay_counter == 24'd0) begin
            st.mode         = MODE_AWAIT;
            st.cancel_count = 3'd0;
          end else if (tick.input_voltage < cfg.min_input_voltage) begin
            st.delay_counter = cfg.on_delay_ticks;
          end
        end
      end
      MODE_RUN: begin
        if (!tick.switch_on) begin
          st.delay_counter = cfg.off_delay_ticks;
          st.mode          = MODE_SHUT;
        end
      end
      MODE_SHUT: begin
        if (st.delay_counter != 24'd0) begin
          st.delay_counter = st.delay_counter - 24'd1;
        end
        if (st.delay_counter == 24'd0) begin
          if (tick.switch_on) begin
            st.mode          = MODE_FAULTOFF;
            st.alarm_timer   = 23'd0;
            st.latched_fault = FAULT_TOGGLE;
          end else begin
            st.mode = MODE_OFF;
          end
        end
      end
      MODE_FAULTED: begin
        st.delay_counter = cfg.off_delay_ticks;
        st.mode          = MODE_FAULTDOWN;
      end
      MODE_FAULTDOWN: begin
        if (st.delay_counter != 24'd0) begin
          st.delay_counter = st.delay_counter - 24'd1;
        end
        if (st.delay_counter == 24'd0) begin
          st.mode        = MODE_FAULTOFF;
          st.alarm_timer = 23'd0;
        end
      end
      MODE_FAULTOFF: begin
        if (!tick.switch_on) begin
          st.mode = MODE_OFF;
        end else begin
          if (st.alarm_timer != 23'd0) begin
            st.alarm_timer = st.alarm_timer - 23'd1;
          end
          if (st.alarm_timer == 23'd0) begin
            alarm          = 1'b1;
            st.alarm_timer = ALARM_PERIOD;
          end
        end
      end
      MODE_DIAG: st.mode = MODE_OFF;
      default: ;
    endcase

    // Cancel count expires after a quiet period
    if (st.cancel_idle_active) begin
      if (st.cancel_idle_timer == 23'd0) begin
        st.cancel_count       = 3'd0;
        st.cancel_idle_active = 1'b0;
      end else begin
        st.cancel_idle_timer = st.cancel_idle_timer - 23'd1;
      end
    end

    // Diag entry
    if (!cfg.diag_entry_disable &&
        (st.cancel_count >= DIAG_CANCELS ||
         (tick.button_pressed && st.cancel_count != 3'd0))) begin
      st.mode         = MODE_DIAG;
      st.cancel_count = 3'd0;
    end

    // Bus check while running
    if (st.mode == MODE_RUN) begin
      if (!hard) begin
        st.fault_running = 1'b0;
        st.fault_timer   = 24'd0;
        red = (tick.bus_voltage > cfg.bus_soft_limit) ? LVL_HALF : LVL_OFF;
      end else begin
        red = LVL_FULL;
        if (!st.fault_running) begin
          st.fault_running = 1'b1;
          st.fault_timer   = cfg.fault_persist_ticks;
        end else if (st.fault_timer == 24'd0) begin
          if (!cfg.fault_override) begin
            st.mode = MODE_FAULTED;
          end
          st.latched_fault = FAULT_BUS_OV;
        end else begin
          st.fault_timer = st.fault_timer - 24'd1;
        end
      end
    end else begin
      st.fault_running = 1'b0;
      st.fault_timer   = 24'd0;
    end

    if (st.mode == MODE_OFF) begin
      st.latched_fault = FAULT_NONE;
    end

    // Indicators
    unique case (st.mode) inside
      MODE_OFF, MODE_FAULTOFF, MODE_DIAG: green = LVL_OFF;
      MODE_ONDELAY, MODE_RUN:             green = LVL_HALF;
      default:                            green = LVL_FULL;
    endcase
    if (st.mode == MODE_FAULTED || st.mode == MODE_FAULTDOWN ||
        st.mode == MODE_FAULTOFF) begin
      red = LVL_FULL;
    end
  end

  // Result word
  always_comb begin
    res.mode               = st.mode;
    res.green_level        = green;
    res.red_level          = red;
    res.power_stage_enable = (st.mode >= MODE_RUN) && (st.mode <= MODE_FAULTDOWN);
    res.ramp_remaining     = (st.mode == MODE_SHUT || st.mode == MODE_FAULTDOWN) ?
                             st.delay_counter : 24'd0;
    res.alarm_pulse        = alarm;
    res.fault_code         = st.latched_fault;
  end

  assign st_next = st;

endmodule

// ===== src/inverter_start_stop_sequencer.sv =====
// Top level of the inverter start/stop sequencer.
`timescale 1ns / 1ps
// Each input word is one microsecond tick (switch, button, input and bus
// voltage, zero crossing) and yields exactly one result word (mode, indicator
// levels, power stage enable, ramp count, alarm pulse, fault code). The block
// takes one tick per clock cycle while the result side is not stalled: a tick
// sits in the input register, then the step logic updates the sequencer state
// and loads the result register once that register is empty or its word is
// being taken, and out_valid rises with the loaded word and holds until
// out_ready takes it. The input register and the result register together
// absorb a stall on the result side. Configuration writes go to cfg_index
// 0..7 and are always accepted; write them only while idle.
module inverter_start_stop_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // tick input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_switch_on,
  input  logic        in_button_pressed,
  input  logic [15:0] in_input_voltage,
  input  logic [15:0] in_bus_voltage,
  input  logic        in_zero_crossing,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_mode,
  output logic [7:0]  out_green_level,
  output logic [7:0]  out_red_level,
  output logic        out_power_stage_enable,
  output logic [23:0] out_ramp_remaining,
  output logic        out_alarm_pulse,
  output logic [1:0]  out_fault_code,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import iss_pkg::*;

  iss_cfg_t   cfg;
  iss_in_t    tick_r, tick_nxt;
  logic       tick_valid_r, tick_valid_nxt;
  iss_state_t st_r, st_step;
  iss_out_t   res_r, res_step;
  logic       out_valid_r, out_valid_nxt;
  logic       advance;
  logic       in_fire;

  assign cfg_ready = 1'b1;

  iss_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  iss_step u_step (
    .cfg     (cfg),
    .st_cur  (st_r),
    .tick    (tick_r),
    .st_next (st_step),
    .res     (res_step)
  );

  // Handshake control
  assign advance  = tick_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !tick_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    tick_nxt.switch_on      = in_switch_on;
    tick_nxt.button_pressed = in_button_pressed;
    tick_nxt.input_voltage  = in_input_voltage;
    tick_nxt.bus_voltage    = in_bus_voltage;
    tick_nxt.zero_crossing  = in_zero_crossing;
    tick_valid_nxt = in_fire ? 1'b1 : (advance ? 1'b0 : tick_valid_r);
    out_valid_nxt  = advance ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);
  end

  // Valid flags and sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_valid_r          <= 1'b0;
      out_valid_r           <= 1'b0;
      st_r.mode             <= MODE_OFF;
      st_r.delay_counter    <= 24'd0;
      st_r.fault_timer      <= 24'd0;
      st_r.fault_running    <= 1'b0;
      st_r.alarm_timer      <= 23'd0;
      st_r.cancel_count     <= 3'd0;
      st_r.cancel_idle_timer <= 23'd0;
      st_r.cancel_idle_active <= 1'b0;
      st_r.latched_fault    <= FAULT_NONE;
    end else begin
      tick_valid_r <= tick_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (advance) begin
        st_r <= st_step;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      tick_r <= tick_nxt;
    end
    if (advance) begin
      res_r <= res_step;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_mode               = res_r.mode;
  assign out_green_level        = res_r.green_level;
  assign out_red_level          = res_r.red_level;
  assign out_power_stage_enable = res_r.power_stage_enable;
  assign out_ramp_remaining     = res_r.ramp_remaining;
  assign out_alarm_pulse        = res_r.alarm_pulse;
  assign out_fault_code         = res_r.fault_code;

  // Input stalls only when both registers are full and the output is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (tick_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a full pipeline");

  // Fault code is cleared whenever the sequencer rests in off
  a_off_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mode == MODE_OFF |-> st_r.latched_fault == FAULT_NONE)
    else $error("fault code held in off mode");

  // Ramp count only shows during a ramp-down
  a_ramp_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.ramp_remaining != 24'd0) |->
      (res_r.mode == MODE_SHUT || res_r.mode == MODE_FAULTDOWN))
    else $error("ramp count outside ramp-down");

  // Alarm fires only in faultoff
  a_alarm_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.alarm_pulse) |-> res_r.mode == MODE_FAULTOFF)
    else $error("alarm pulse outside faultoff");

endmodule
